[hw/rtl/lcsd_pkg.sv]
// ----------------------------------------------------------------------------
// lcsd_pkg
// Shared constants, types and command/status bundles of the label count
// snapshot and difference block.
// ----------------------------------------------------------------------------
package lcsd_pkg;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned IDX_W        = $clog2(ENTRIES);
  localparam int unsigned CNT_W        = $clog2(ENTRIES + 1);
  localparam int unsigned LABEL_BITS   = 8;
  localparam int unsigned COUNT_BITS   = 16;
  localparam int unsigned LIMIT_W      = 7;
  localparam int unsigned RESULT_LIMIT = 64;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_DET    = 2'd1,
    KIND_DOOR   = 2'd2,
    KIND_REPORT = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DET_RD,
    ST_DET_CMP,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_OUT_CHK,
    ST_OUT_LD,
    ST_IN_RD,
    ST_IN_CMP,
    ST_EVAL,
    ST_FIN
  } state_e;

  typedef enum logic {
    ACT_PUT  = 1'b0,
    ACT_TAKE = 1'b1
  } action_e;

  typedef struct packed {
    logic [LABEL_BITS-1:0] label;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef struct packed {
    logic load_lab;
    logic clr_used;
    logic j_clr;
    logic j_inc;
    logic i_inc;
    logic rep_rd;
    logic det_inc;
    logic det_app;
    logic cpy_start;
    logic cpy_wr;
    logic door_close;
    logic rep_start;
    logic phase_next;
    logic ld_entry;
    logic ld_other;
    logic take_event;
    logic out_from_hold;
    logic out_final;
  } cmd_t;

  typedef struct packed {
    logic cur_full;
    logic door_open;
    logic pending;
    logic j_end_cur;
    logic j_end_inner;
    logic outer_done;
    logic match_det;
    logic match_inner;
    logic grew;
    logic hold_valid;
    logic phase;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/lcsd_ctrl.sv]
// ----------------------------------------------------------------------------
// lcsd_ctrl
// Sequencer: decodes accepted items and steps the datapath through table
// search, baseline copy and report walk.
// ----------------------------------------------------------------------------
module lcsd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_kind_i,
  input  logic                 in_door_closed_i,
  input  lcsd_pkg::sts_t       sts_i,
  output logic                 in_stall_o,
  output lcsd_pkg::cmd_t       cmd_o
);
  import lcsd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(in_kind_i))
            KIND_FRAME: cmd_o.clr_used = 1'b1;
            KIND_DET: begin
              if (!sts_i.cur_full) begin
                cmd_o.load_lab = 1'b1;
                cmd_o.j_clr    = 1'b1;
                state_d        = ST_DET_RD;
              end
            end
            KIND_DOOR: begin
              if (!sts_i.door_open && !in_door_closed_i) begin
                cmd_o.cpy_start = 1'b1;
                cmd_o.j_clr     = 1'b1;
                state_d         = ST_CPY_RD;
              end else if (sts_i.door_open && in_door_closed_i) begin
                cmd_o.door_close = 1'b1;
              end
            end
            KIND_REPORT: begin
              if (sts_i.pending) begin
                cmd_o.rep_start = 1'b1;
                state_d         = ST_OUT_CHK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DET_RD: begin
        if (sts_i.j_end_cur) begin
          cmd_o.det_app = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_DET_CMP;
        end
      end
      ST_DET_CMP: begin
        if (sts_i.match_det) begin
          cmd_o.det_inc = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_DET_RD;
        end
      end
      ST_CPY_RD: begin
        state_d = sts_i.j_end_cur ? ST_IDLE : ST_CPY_WR;
      end
      ST_CPY_WR: begin
        cmd_o.cpy_wr = 1'b1;
        cmd_o.j_inc  = 1'b1;
        state_d      = ST_CPY_RD;
      end
      ST_OUT_CHK: begin
        cmd_o.rep_rd = 1'b1;
        if (sts_i.outer_done) begin
          if (!sts_i.phase) begin
            cmd_o.phase_next = 1'b1;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        cmd_o.ld_entry = 1'b1;
        cmd_o.j_clr    = 1'b1;
        state_d        = ST_IN_RD;
      end
      ST_IN_RD: begin
        cmd_o.rep_rd = 1'b1;
        state_d      = sts_i.j_end_inner ? ST_EVAL : ST_IN_CMP;
      end
      ST_IN_CMP: begin
        if (sts_i.match_inner) begin
          cmd_o.ld_other = 1'b1;
          state_d        = ST_EVAL;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_IN_RD;
        end
      end
      ST_EVAL: begin
        if (!sts_i.grew) begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_OUT_CHK;
        end else if (!sts_i.hold_valid) begin
          cmd_o.take_event = 1'b1;
          cmd_o.i_inc      = 1'b1;
          state_d          = ST_OUT_CHK;
        end else if (sts_i.out_free) begin
          cmd_o.out_from_hold = 1'b1;
          cmd_o.take_event    = 1'b1;
          cmd_o.i_inc         = 1'b1;
          state_d             = ST_OUT_CHK;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_final = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/lcsd_dp.sv]
// ----------------------------------------------------------------------------
// lcsd_dp
// Datapath: current and baseline tables, indexes, flags, event hold stage
// and output register.
// ----------------------------------------------------------------------------
module lcsd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lcsd_pkg::LABEL_BITS-1:0]      in_label_i,
  input  logic                                 cfg_we_i,
  input  logic [lcsd_pkg::LIMIT_W-1:0]         cfg_max_events_per_report_i,
  input  lcsd_pkg::cmd_t                       cmd_i,
  output lcsd_pkg::sts_t                       sts_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic                                 out_has_event_o,
  output logic                                 out_action_o,
  output logic [lcsd_pkg::LABEL_BITS-1:0]      out_event_label_o,
  output logic [lcsd_pkg::COUNT_BITS-1:0]      out_count_change_o,
  output logic                                 out_last_o
);
  import lcsd_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  entry_t cur_mem  [ENTRIES];
  entry_t base_mem [ENTRIES];
  entry_t cur_rd_q, base_rd_q;

  logic [CNT_W-1:0]      cur_used_q, base_used_q, i_q, j_q;
  logic [LIMIT_W-1:0]    limit_q, n_q, limit_eff;
  logic                  door_open_q, pending_q, phase_q;
  logic [LABEL_BITS-1:0] lab_q, entry_lab_q;
  logic [COUNT_BITS-1:0] entry_cnt_q, other_q, diff;

  logic                  hold_valid_q, hold_action_q;
  logic [LABEL_BITS-1:0] hold_label_q;
  logic [COUNT_BITS-1:0] hold_diff_q;

  logic                  out_valid_q, out_has_q, out_action_q, out_last_q;
  logic [LABEL_BITS-1:0] out_label_q;
  logic [COUNT_BITS-1:0] out_diff_q;

  logic [IDX_W-1:0]      cur_raddr, base_raddr, cur_waddr;
  logic                  cur_we;
  entry_t                cur_wdata, outer_rd, inner_rd;
  logic [CNT_W-1:0]      used_a, used_b;
  logic                  out_free, out_load;

  // Index selection: outer walk uses i, inner search uses j
  assign cur_raddr  = (cmd_i.rep_rd && !phase_q) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  assign base_raddr = phase_q ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];

  assign cur_we    = cmd_i.det_inc | cmd_i.det_app;
  assign cur_waddr = cmd_i.det_app ? cur_used_q[IDX_W-1:0] : j_q[IDX_W-1:0];
  always_comb begin
    cur_wdata.label = lab_q;
    if (cmd_i.det_app) begin
      cur_wdata.count = COUNT_BITS'(1);
    end else if (cur_rd_q.count == COUNT_MAX) begin
      cur_wdata.count = cur_rd_q.count;
    end else begin
      cur_wdata.count = cur_rd_q.count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rd_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cpy_wr) begin
      base_mem[j_q[IDX_W-1:0]] <= cur_rd_q;
    end
    base_rd_q <= base_mem[base_raddr];
  end

  assign outer_rd = phase_q ? base_rd_q : cur_rd_q;
  assign inner_rd = phase_q ? cur_rd_q : base_rd_q;
  assign used_a   = phase_q ? base_used_q : cur_used_q;
  assign used_b   = phase_q ? cur_used_q : base_used_q;
  assign diff     = entry_cnt_q - other_q;

  // Register value 0 acts as 1, anything past the table limit clamps
  always_comb begin
    if (limit_q == '0) begin
      limit_eff = LIMIT_W'(1);
    end else if (limit_q > LIMIT_W'(RESULT_LIMIT)) begin
      limit_eff = LIMIT_W'(RESULT_LIMIT);
    end else begin
      limit_eff = limit_q;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.out_from_hold | cmd_i.out_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_used_q   <= '0;
      base_used_q  <= '0;
      door_open_q  <= 1'b0;
      pending_q    <= 1'b0;
      phase_q      <= 1'b0;
      limit_q      <= LIMIT_W'(RESULT_LIMIT);
      n_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_max_events_per_report_i;
      if (cmd_i.clr_used) cur_used_q <= '0;
      if (cmd_i.det_app) cur_used_q <= cur_used_q + CNT_W'(1);
      if (cmd_i.cpy_start) begin
        door_open_q <= 1'b1;
        base_used_q <= cur_used_q;
      end
      if (cmd_i.door_close) begin
        door_open_q <= 1'b0;
        pending_q   <= 1'b1;
      end
      if (cmd_i.j_clr) j_q <= '0;
      if (cmd_i.j_inc) j_q <= j_q + CNT_W'(1);
      if (cmd_i.i_inc) i_q <= i_q + CNT_W'(1);
      if (cmd_i.rep_start) begin
        pending_q    <= 1'b0;
        phase_q      <= 1'b0;
        n_q          <= '0;
        i_q          <= '0;
        hold_valid_q <= 1'b0;
      end
      if (cmd_i.phase_next) begin
        phase_q <= 1'b1;
        i_q     <= '0;
      end
      if (cmd_i.take_event) begin
        hold_valid_q <= 1'b1;
        n_q          <= n_q + LIMIT_W'(1);
      end
      if (cmd_i.out_final) hold_valid_q <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_lab) lab_q <= in_label_i;
    if (cmd_i.ld_entry) begin
      entry_lab_q <= outer_rd.label;
      entry_cnt_q <= outer_rd.count;
      other_q     <= '0;
    end
    if (cmd_i.ld_other) other_q <= inner_rd.count;
    if (cmd_i.take_event) begin
      hold_action_q <= phase_q ? ACT_TAKE : ACT_PUT;
      hold_label_q  <= entry_lab_q;
      hold_diff_q   <= diff;
    end
    if (out_load) begin
      out_has_q    <= hold_valid_q;
      out_action_q <= hold_valid_q ? hold_action_q : ACT_PUT;
      out_label_q  <= hold_valid_q ? hold_label_q : '0;
      out_diff_q   <= hold_valid_q ? hold_diff_q : '0;
      out_last_q   <= cmd_i.out_final;
    end
  end

  assign sts_o.cur_full    = (cur_used_q >= CNT_W'(ENTRIES));
  assign sts_o.door_open   = door_open_q;
  assign sts_o.pending     = pending_q;
  assign sts_o.j_end_cur   = (j_q >= cur_used_q);
  assign sts_o.j_end_inner = (j_q >= used_b);
  assign sts_o.outer_done  = (i_q >= used_a) || (n_q >= limit_eff);
  assign sts_o.match_det   = (cur_rd_q.label == lab_q);
  assign sts_o.match_inner = (inner_rd.label == entry_lab_q);
  assign sts_o.grew        = (entry_cnt_q > other_q);
  assign sts_o.hold_valid  = hold_valid_q;
  assign sts_o.phase       = phase_q;
  assign sts_o.out_free    = out_free;

  assign out_valid_o        = out_valid_q;
  assign out_has_event_o    = out_has_q;
  assign out_action_o       = out_action_q;
  assign out_event_label_o  = out_label_q;
  assign out_count_change_o = out_diff_q;
  assign out_last_o         = out_last_q;

endmodule

[hw/rtl/label_count_snapshot_diff_top.sv]
// ----------------------------------------------------------------------------
// label_count_snapshot_diff_top
// Per-label detection counting with door-triggered baseline snapshot and
// put-in / take-out difference reports.
// ----------------------------------------------------------------------------
// Sequence: frame clear and door close act on acceptance; detection reads
//   and compares the entries in use one at a time; baseline copy reads and
//   writes each entry in use; reports walk each table against the other.
// Throughput: one item at a time; input stalls while the sequencer is busy.
// Reset: async active low clears counts in use, door, pending flag, limit
//   (to 64) and output valid; table contents are not cleared and need no pass.
module label_count_snapshot_diff_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input item beat
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        in_kind_i,
  input  logic [lcsd_pkg::LABEL_BITS-1:0]   in_label_i,
  input  logic                              in_door_closed_i,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [lcsd_pkg::LIMIT_W-1:0]      cfg_max_events_per_report_i,
  // result beat
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              out_has_event_o,
  output logic                              out_action_o,
  output logic [lcsd_pkg::LABEL_BITS-1:0]   out_event_label_o,
  output logic [lcsd_pkg::COUNT_BITS-1:0]   out_count_change_o,
  output logic                              out_last_o
);
  import lcsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer owns the state; it only talks to the datapath via cmd/sts.
  lcsd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_kind_i        (in_kind_i),
    .in_door_closed_i (in_door_closed_i),
    .sts_i            (sts),
    .in_stall_o       (in_stall_o),
    .cmd_o            (cmd)
  );

  // Tables, indexes and the output register. Events are held one deep so
  // the last one of a report can be tagged once the walk is finished.
  lcsd_dp u_dp (
    .clk_i                       (clk_i),
    .rst_ni                      (rst_ni),
    .in_label_i                  (in_label_i),
    .cfg_we_i                    (cfg_we_i),
    .cfg_max_events_per_report_i (cfg_max_events_per_report_i),
    .cmd_i                       (cmd),
    .sts_o                       (sts),
    .out_stall_i                 (out_stall_i),
    .out_valid_o                 (out_valid_o),
    .out_has_event_o             (out_has_event_o),
    .out_action_o                (out_action_o),
    .out_event_label_o           (out_event_label_o),
    .out_count_change_o          (out_count_change_o),
    .out_last_o                  (out_last_o)
  );

  // Empty report beat always closes the report.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_has_event_o) |-> out_last_o)
    else $error("empty report beat without last");

  // Only one write source for the current table per cycle.
  a_cur_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.det_inc, cmd.det_app}))
    else $error("two writes to current table");

  // Never append to a full table.
  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.det_app |-> !sts.cur_full)
    else $error("append on full table");

  // Output register is only reloaded when free.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_from_hold || cmd.out_final) |-> sts.out_free)
    else $error("output overwritten while stalled");

endmodule

[test/label_count_snapshot_diff_top_tb.sv]
// ----------------------------------------------------------------------------
// label_count_snapshot_diff_top_tb
// Drives frame clears, detections, door changes and report requests into the
// label count block, predicts every report beat and compares field by field.
// ----------------------------------------------------------------------------
module label_count_snapshot_diff_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcsd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 60000;
  localparam int unsigned SETTLE_CYCLES  = 400;   // > worst detection/copy time
  localparam int unsigned RANDOM_ITEMS   = 370;

  typedef struct {
    logic                  has_event;
    logic                  action;
    logic [LABEL_BITS-1:0] event_label;
    logic [COUNT_BITS-1:0] count_change;
    logic                  last;
  } report_beat_t;

  // Tracks the count tables, door and pending flag, and queues the report
  // beats each accepted item should produce.
  class count_diff_board;
    logic [LABEL_BITS-1:0] cur_lab [ENTRIES];
    logic [COUNT_BITS-1:0] cur_cnt [ENTRIES];
    int unsigned           cur_used;
    logic [LABEL_BITS-1:0] base_lab [ENTRIES];
    logic [COUNT_BITS-1:0] base_cnt [ENTRIES];
    int unsigned           base_used;
    bit                    door_open;
    bit                    pending;
    int unsigned           limit;
    report_beat_t          beats_q[$];
    int unsigned           mismatches;
    int unsigned           reports;

    function new();
      cur_used = 0; base_used = 0; door_open = 0; pending = 0;
      limit = RESULT_LIMIT; mismatches = 0; reports = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = (v == 0) ? 1 : (v > RESULT_LIMIT) ? RESULT_LIMIT : v;
    endfunction

    function automatic logic [COUNT_BITS-1:0] find_count(bit in_base,
                                                         logic [LABEL_BITS-1:0] lab);
      int unsigned n;
      n = in_base ? base_used : cur_used;
      for (int unsigned i = 0; i < n; i++) begin
        if (in_base && base_lab[i] == lab) return base_cnt[i];
        if (!in_base && cur_lab[i] == lab) return cur_cnt[i];
      end
      return '0;
    endfunction

    function void add_beat(logic has, logic act, logic [LABEL_BITS-1:0] lab,
                           logic [COUNT_BITS-1:0] chg);
      report_beat_t b;
      b.has_event = has; b.action = act; b.event_label = lab;
      b.count_change = chg; b.last = 1'b0;
      beats_q.push_back(b);
    endfunction

    function void note_item(kind_e kind, logic [LABEL_BITS-1:0] lab, logic closed);
      int unsigned n;
      logic [COUNT_BITS-1:0] other;
      bit hit;
      case (kind)
        KIND_FRAME: cur_used = 0;
        KIND_DET: begin
          if (cur_used < ENTRIES) begin
            hit = 1'b0;
            for (int unsigned i = 0; i < cur_used && !hit; i++) begin
              if (cur_lab[i] == lab) begin
                hit = 1'b1;
                if (cur_cnt[i] != '1) cur_cnt[i]++;
              end
            end
            if (!hit) begin
              cur_lab[cur_used] = lab;
              cur_cnt[cur_used] = COUNT_BITS'(1);
              cur_used++;
            end
          end
        end
        KIND_DOOR: begin
          if (!door_open && !closed) begin
            door_open = 1;
            base_lab = cur_lab;
            base_cnt = cur_cnt;
            base_used = cur_used;
          end else if (door_open && closed) begin
            door_open = 0;
            pending = 1;
          end
        end
        default: begin
          if (pending) begin
            pending = 0;
            reports++;
            n = 0;
            for (int unsigned i = 0; i < cur_used && n < limit; i++) begin
              other = find_count(1'b1, cur_lab[i]);
              if (cur_cnt[i] > other) begin
                add_beat(1'b1, ACT_PUT, cur_lab[i], cur_cnt[i] - other);
                n++;
              end
            end
            for (int unsigned i = 0; i < base_used && n < limit; i++) begin
              other = find_count(1'b0, base_lab[i]);
              if (base_cnt[i] > other) begin
                add_beat(1'b1, ACT_TAKE, base_lab[i], base_cnt[i] - other);
                n++;
              end
            end
            if (n == 0) add_beat(1'b0, ACT_PUT, '0, '0);
            beats_q[beats_q.size()-1].last = 1'b1;
          end
        end
      endcase
    endfunction

    function void check_beat(report_beat_t got);
      report_beat_t exp_b;
      if (beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: has=%0d act=%0d lab=%0d chg=%0d last=%0d",
                   got.has_event, got.action, got.event_label, got.count_change,
                   got.last);
        return;
      end
      exp_b = beats_q.pop_front();
      if (got.has_event !== exp_b.has_event || got.action !== exp_b.action ||
          got.event_label !== exp_b.event_label ||
          got.count_change !== exp_b.count_change || got.last !== exp_b.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch: exp has=%0d act=%0d lab=%0d chg=%0d last=%0d",
                   exp_b.has_event, exp_b.action, exp_b.event_label,
                   exp_b.count_change, exp_b.last);
          $display("               got has=%0d act=%0d lab=%0d chg=%0d last=%0d",
                   got.has_event, got.action, got.event_label, got.count_change,
                   got.last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            in_kind_i = '0;
  logic [LABEL_BITS-1:0] in_label_i = '0;
  logic                  in_door_closed_i = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]    cfg_max_events_per_report_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  out_has_event_o;
  logic                  out_action_o;
  logic [LABEL_BITS-1:0] out_event_label_o;
  logic [COUNT_BITS-1:0] out_count_change_o;
  logic                  out_last_o;

  count_diff_board board = new();

  // 0: sender idles 29%, receiver 74%; 1: swapped; 2: no idling
  int unsigned idle_mode = 2;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned quiet_cycles = 0;

  label_count_snapshot_diff_top i_dut (
    .clk_i                       (clk_i),
    .rst_ni                      (rst_ni),
    .in_valid_i                  (in_valid_i),
    .in_stall_o                  (in_stall_o),
    .in_kind_i                   (in_kind_i),
    .in_label_i                  (in_label_i),
    .in_door_closed_i            (in_door_closed_i),
    .cfg_we_i                    (cfg_we_i),
    .cfg_max_events_per_report_i (cfg_max_events_per_report_i),
    .out_valid_o                 (out_valid_o),
    .out_stall_i                 (out_stall_i),
    .out_has_event_o             (out_has_event_o),
    .out_action_o                (out_action_o),
    .out_event_label_o           (out_event_label_o),
    .out_count_change_o          (out_count_change_o),
    .out_last_o                  (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall decided at the falling edge, beats taken at the rising one.
  always @(negedge clk_i) begin
    case (idle_mode)
      0:       out_stall_i = ($urandom_range(0, 99) < 74);
      1:       out_stall_i = ($urandom_range(0, 99) < 29);
      default: out_stall_i = 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    report_beat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.has_event = out_has_event_o;
      got.action = out_action_o;
      got.event_label = out_event_label_o;
      got.count_change = out_count_change_o;
      got.last = out_last_o;
      board.check_beat(got);
      beats_out++;
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats still due",
               quiet_cycles, board.beats_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One input beat; called at a falling edge, returns at a falling edge.
  // Valid stays high across back-to-back beats.
  task automatic send_item(kind_e kind, logic [LABEL_BITS-1:0] lab, logic closed);
    int unsigned idle_pct;
    idle_pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 74 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_kind_i = kind;
    in_label_i = lab;
    in_door_closed_i = closed;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(kind, lab, closed);
    beats_in++;
    @(negedge clk_i);
  endtask

  // Sender holds off until every due beat is out and the block has settled.
  task automatic drain();
    in_valid_i = 1'b0;
    while (board.beats_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain();
    cfg_max_events_per_report_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_limit(v);
  endtask

  task automatic random_session();
    logic [LABEL_BITS-1:0] pool [8];
    int unsigned pool_n;
    int unsigned big;
    big = ($urandom_range(0, 99) < 2);
    pool_n = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++) pool[i] = LABEL_BITS'($urandom_range(0, 255));
    if ($urandom_range(0, 9) != 0)
      send_item(KIND_FRAME, LABEL_BITS'($urandom), 1'($urandom));
    if (big) begin
      // fill the table past its size with mostly distinct labels
      for (int i = 0; i < 70; i++)
        send_item(KIND_DET, LABEL_BITS'($urandom_range(0, 255)), 1'($urandom));
    end else begin
      repeat ($urandom_range(0, 6)) send_item(KIND_DET, pool[$urandom_range(0, pool_n-1)],
                                              1'($urandom));
    end
    send_item(KIND_DOOR, LABEL_BITS'($urandom), 1'b0);
    if ($urandom_range(0, 4) != 0)
      send_item(KIND_FRAME, LABEL_BITS'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 6)) send_item(KIND_DET, pool[$urandom_range(0, pool_n-1)],
                                            1'($urandom));
    // noise: stray items of any kind
    while ($urandom_range(0, 99) < 20)
      send_item(kind_e'($urandom_range(0, 3)), LABEL_BITS'($urandom), 1'($urandom));
    send_item(KIND_DOOR, LABEL_BITS'($urandom), 1'b1);
    send_item(KIND_REPORT, LABEL_BITS'($urandom), 1'($urandom));
  endtask

  initial begin
    int unsigned start_in;
    int unsigned sessions;
    logic [LIMIT_W-1:0] lim_pick;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    send_item(KIND_REPORT, 8'h00, 1'b0);          // nothing pending
    send_item(KIND_DET, 8'h00, 1'b1);             // before any frame clear
    send_item(KIND_DET, 8'hFF, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);            // closed while closed
    send_item(KIND_DOOR, 8'hFF, 1'b0);            // open: baseline {00:1, FF:1}
    send_item(KIND_DOOR, 8'h00, 1'b0);            // open while open
    send_item(KIND_FRAME, 8'hFF, 1'b1);
    repeat (3) send_item(KIND_DET, 8'hFF, 1'b0);
    send_item(KIND_DET, 8'h07, 1'b1);
    send_item(KIND_DOOR, 8'h00, 1'b1);            // close: report pending
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_REPORT, 8'h00, 1'b0);          // put FF+2, put 07+1, take 00-1
    send_item(KIND_REPORT, 8'h00, 1'b0);          // already consumed
    send_item(KIND_DOOR, 8'h00, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_REPORT, 8'h00, 1'b0);          // no differences
    // reopen while pending takes a fresh baseline
    send_item(KIND_DOOR, 8'h00, 1'b0);
    send_item(KIND_FRAME, 8'h00, 1'b0);
    send_item(KIND_DET, 8'h01, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_DOOR, 8'h00, 1'b0);
    send_item(KIND_DET, 8'h01, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_REPORT, 8'h00, 1'b0);

    // full table: later detections ignored, even of a present label
    write_limit(7'd127);                          // clamps to 64
    send_item(KIND_FRAME, 8'h00, 1'b0);
    for (int i = 0; i < ENTRIES; i++) send_item(KIND_DET, 8'(i * 4 + 3), 1'b0);
    send_item(KIND_DET, 8'h80, 1'b0);
    send_item(KIND_DET, 8'h03, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b0);
    send_item(KIND_FRAME, 8'h00, 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_REPORT, 8'h00, 1'b0);          // 64 take-out beats
    write_limit(7'd0);                            // acts as one
    send_item(KIND_DOOR, 8'h00, 1'b0);
    for (int i = 0; i < 5; i++) send_item(KIND_DET, 8'(i), 1'b0);
    send_item(KIND_DOOR, 8'h00, 1'b1);
    send_item(KIND_REPORT, 8'h00, 1'b0);
    write_limit(7'd64);

    // ---- random part, three idling phases ----
    start_in = beats_in;
    sessions = 0;
    while (beats_in - start_in < RANDOM_ITEMS) begin
      idle_mode = ((beats_in - start_in) * 3) / RANDOM_ITEMS;
      if (sessions % 6 == 5) begin
        case ($urandom_range(0, 5))
          0:       lim_pick = 7'd0;
          1:       lim_pick = 7'd1;
          2:       lim_pick = 7'd64;
          3:       lim_pick = 7'd127;
          4:       lim_pick = LIMIT_W'($urandom_range(2, 4));
          default: lim_pick = LIMIT_W'($urandom);
        endcase
        write_limit(lim_pick);
      end
      random_session();
      sessions++;
    end
    idle_mode = 2;

    in_valid_i = 1'b0;
    while (board.beats_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("covered %0d input beats, %0d reports, %0d result beats", beats_in,
             board.reports, beats_out);
    $display("including full table, limit clamps, reopen while pending and three idling mixes");
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", board.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
